### design/lcdimg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdimg_pkg
// Shared types, glyph tables and pin placement helpers for the LCD image
// builder (6 digits, 4 commons, 10-byte segment RAM image).
// ----------------------------------------------------------------------------
package lcdimg_pkg;

    // Seven-segment pattern, bit 0 = segment a ... bit 6 = segment g
    typedef logic [6:0] t_seg_pat;

    localparam int DIGIT_COUNT = 6;
    localparam int SEG_COUNT   = 7;
    localparam int IMG_BITS    = 80;

    localparam t_seg_pat SEG_A = 7'h01;
    localparam t_seg_pat SEG_B = 7'h02;
    localparam t_seg_pat SEG_C = 7'h04;
    localparam t_seg_pat SEG_D = 7'h08;
    localparam t_seg_pat SEG_E = 7'h10;
    localparam t_seg_pat SEG_F = 7'h20;
    localparam t_seg_pat SEG_G = 7'h40;

    // Character codes with a glyph of their own
    localparam logic [7:0] CHR_0 = 8'h30;
    localparam logic [7:0] CHR_9 = 8'h39;
    localparam logic [7:0] CHR_A = 8'h41;
    localparam logic [7:0] CHR_B = 8'h42;
    localparam logic [7:0] CHR_C = 8'h43;
    localparam logic [7:0] CHR_D = 8'h44;
    localparam logic [7:0] CHR_E = 8'h45;
    localparam logic [7:0] CHR_F = 8'h46;
    localparam logic [7:0] CHR_L = 8'h4C;
    localparam logic [7:0] CHR_O = 8'h4F;
    localparam logic [7:0] CHR_S = 8'h53;
    localparam logic [7:0] CHR_T = 8'h54;

    localparam logic [3:0] DEC_RADIX = 4'd10;

    // Icon positions on the glass
    localparam int ICON_T_PIN     = 1;
    localparam int ICON_COLON_PIN = 6;
    localparam int ICON_DOT_PIN   = 9;
    localparam int ICON_COM       = 3;

    // Decimal digit patterns
    function automatic t_seg_pat digit_pat(input logic [3:0] v);
        t_seg_pat p;
        case (v)
            4'd0:    p = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1:    p = SEG_B | SEG_C;
            4'd2:    p = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
            4'd3:    p = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4:    p = SEG_B | SEG_C | SEG_F | SEG_G;
            4'd5:    p = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
            4'd6:    p = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd7:    p = SEG_A | SEG_B | SEG_C;
            4'd8:    p = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd9:    p = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
            default: p = '0;
        endcase
        return p;
    endfunction

    // Nibble to upper-case hex ASCII
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < DEC_RADIX) begin
            c = CHR_0 + {4'd0, v};
        end else begin
            c = CHR_A + {4'd0, v - DEC_RADIX};
        end
        return c;
    endfunction

    // Pin offset within a digit for segments a..g
    function automatic int seg_pin_off(input int s);
        return (s < 3) ? 1 : 0;
    endfunction

    // Glass common for segments a..g
    function automatic int seg_com(input int s);
        int c;
        case (s)
            0:       c = 0;
            1:       c = 1;
            2:       c = 2;
            3:       c = 3;
            4:       c = 2;
            5:       c = 0;
            default: c = 1;
        endcase
        return c;
    endfunction

    // Flat image bit for a glass pin and common: byte seg/2, nibble by seg parity
    function automatic logic [6:0] img_bit(input int pin, input int com);
        int seg;
        int pos;
        seg = 19 - pin;
        pos = ((seg >> 1) << 3) + ((seg & 1) << 2) + (3 - com);
        return pos[6:0];
    endfunction

endpackage

### design/lcdimg_char_dec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdimg_char_dec
// Character decoder: raw 0-9, ASCII digits and ten letter glyphs to a
// seven-segment pattern; any other code decodes to blank.
// ----------------------------------------------------------------------------
module lcdimg_char_dec
    import lcdimg_pkg::*;
(
    input  logic [7:0] i_code,
    output t_seg_pat   o_pat
);

    // Pick digit table, ASCII digit table or letter glyph
    always_comb begin
        if (i_code < {4'd0, DEC_RADIX}) begin
            o_pat = digit_pat(i_code[3:0]);
        end else if (i_code >= CHR_0 && i_code <= CHR_9) begin
            o_pat = digit_pat(i_code[3:0]);
        end else begin
            case (i_code)
                CHR_A:   o_pat = SEG_A | SEG_B | SEG_C | SEG_E | SEG_F | SEG_G;
                CHR_B:   o_pat = SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
                CHR_C:   o_pat = SEG_A | SEG_D | SEG_E | SEG_F;
                CHR_D:   o_pat = SEG_B | SEG_C | SEG_D | SEG_E | SEG_G;
                CHR_E:   o_pat = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G;
                CHR_F:   o_pat = SEG_A | SEG_E | SEG_F | SEG_G;
                CHR_S:   o_pat = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
                CHR_L:   o_pat = SEG_D | SEG_E | SEG_F;
                CHR_O:   o_pat = SEG_C | SEG_D | SEG_E | SEG_G;
                CHR_T:   o_pat = SEG_D | SEG_E | SEG_F | SEG_G;
                default: o_pat = '0;
            endcase
        end
    end

endmodule

### design/seven_segment_lcd_image_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_lcd_image_builder_top
// Forms the 10-byte segment RAM image and blink setting for a 6-digit,
// 4-common LCD from mode bits, six character codes and six icon flags.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Beat
// command   in         start, busy             mode bits, char0..5, icon flags
// result    out        o_done (strobe)         ram_low, ram_high, blink_enable
// config    in         i_cfg_valid/o_cfg_ready slot number
//
// One beat per cycle; busy is always low. A command beat goes through the
// input register, then the result register. o_done is high for a single
// cycle; the result holds until the next. The receiver cannot stall the result.
// Synchronous active-low reset clears the valid flags and the slot number.
// ----------------------------------------------------------------------------
module seven_segment_lcd_image_builder_top
    import lcdimg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_blank,
    input  logic        i_identify,
    input  logic        i_flashing,
    input  logic [7:0]  i_char0,
    input  logic [7:0]  i_char1,
    input  logic [7:0]  i_char2,
    input  logic [7:0]  i_char3,
    input  logic [7:0]  i_char4,
    input  logic [7:0]  i_char5,
    input  logic [5:0]  i_icon_flags,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output logic        o_done,
    output logic [63:0] o_ram_low,
    output logic [15:0] o_ram_high,
    output logic        o_blink_enable
);

    logic                r_in_valid;
    logic                r_blank;
    logic                r_identify;
    logic                r_flashing;
    logic [7:0]          r_char [DIGIT_COUNT];
    logic [5:0]          r_icons;
    logic [7:0]          r_slot;
    logic                r_done;
    logic [IMG_BITS-1:0] r_img;
    logic                r_blink;

    logic [7:0]          w_code [DIGIT_COUNT];
    t_seg_pat            w_pat  [DIGIT_COUNT];
    logic [IMG_BITS-1:0] n_img;
    logic                n_blink;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Slot number register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slot <= i_cfg_data;
        end
    end

    // Capture the command beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_blank    <= i_blank;
            r_identify <= i_identify;
            r_flashing <= i_flashing;
            r_char[0]  <= i_char0;
            r_char[1]  <= i_char1;
            r_char[2]  <= i_char2;
            r_char[3]  <= i_char3;
            r_char[4]  <= i_char4;
            r_char[5]  <= i_char5;
            r_icons    <= i_icon_flags;
        end
    end

    // Identify mode shows SLOT and the hex slot number
    always_comb begin
        if (r_identify) begin
            w_code[0] = CHR_S;
            w_code[1] = CHR_L;
            w_code[2] = CHR_O;
            w_code[3] = CHR_T;
            w_code[4] = hex_char(r_slot[7:4]);
            w_code[5] = hex_char(r_slot[3:0]);
        end else begin
            for (int d = 0; d < DIGIT_COUNT; d++) begin
                w_code[d] = r_char[d];
            end
        end
    end

    // Decode each digit position
    for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_dec
        lcdimg_char_dec u_dec (
            .i_code (w_code[g]),
            .o_pat  (w_pat[g])
        );
    end

    // Place segments and, outside identify mode, icons on the image; set blink. Blank leaves all clear
    always_comb begin
        n_img   = '0;
        n_blink = 1'b0;
        if (!r_blank) begin
            for (int d = 0; d < DIGIT_COUNT; d++) begin
                for (int s = 0; s < SEG_COUNT; s++) begin
                    if (w_pat[d][s]) begin
                        n_img[img_bit(2 + 2 * d + seg_pin_off(s), seg_com(s))] = 1'b1;
                    end
                end
            end
            if (r_identify) begin
                n_blink = 1'b1;
            end else begin
                for (int k = 0; k < 4; k++) begin
                    if (r_icons[k]) begin
                        n_img[img_bit(ICON_T_PIN, k)] = 1'b1;
                    end
                end
                if (r_icons[4]) begin
                    n_img[img_bit(ICON_COLON_PIN, ICON_COM)] = 1'b1;
                end
                if (r_icons[5]) begin
                    n_img[img_bit(ICON_DOT_PIN, ICON_COM)] = 1'b1;
                end
                n_blink = r_flashing;
            end
        end
    end

    // Result register, strobed for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_img   <= n_img;
            r_blink <= n_blink;
        end
    end

    assign o_done         = r_done;
    assign o_ram_low      = r_img[63:0];
    assign o_ram_high     = r_img[79:64];
    assign o_blink_enable = r_blink;

endmodule
